// ----- design/fdpf_pkg.sv -----
// ----------------------------------------------------------------------------
// fdpf_pkg
// shared types and constants of the fifo demand paging fault unit
// ----------------------------------------------------------------------------
package fdpf_pkg;

    localparam int PAGE_W     = 6;
    localparam int FRAME_W    = 4;
    localparam int CNT_W      = 32;
    localparam int ACT_W      = 2;
    localparam int FRM_CFG_W  = 5;
    localparam int PG_CFG_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // result actions
    localparam logic [ACT_W-1:0] ACT_GRANT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES  = 2'd1;

    localparam logic [FRM_CFG_W-1:0] RST_FRAMES = 5'd16;
    localparam logic [PG_CFG_W-1:0]  RST_PAGES  = 7'd64;

    // page table entry as stored; mapped state is kept in valid bits
    typedef struct packed {
        logic               dirty;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic             take;
        logic             look;
        logic             scan;
        logic             update;
        logic             load;
        logic [ACT_W-1:0] kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic page_ok;
        logic mapped;
        logic hit;
        logic scan_more;
        logic dirty;
        logic out_free;
    } t_sts;

endpackage

// ----- design/fdpf_if.sv -----
// ----------------------------------------------------------------------------
// fdpf channel interfaces
// fault input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface fdpf_in_if import fdpf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] fault_page;

    modport source (output valid, output fault_page, input ready);
    modport sink   (input valid, input fault_page, output ready);
endinterface

interface fdpf_out_if import fdpf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [PAGE_W-1:0]  target_page;
    logic [FRAME_W-1:0] target_frame;
    logic               last;
    logic [CNT_W-1:0]   faults_total;
    logic [CNT_W-1:0]   reads_total;
    logic [CNT_W-1:0]   writes_total;

    modport source (output valid, output action, output target_page,
                    output target_frame, output last, output faults_total,
                    output reads_total, output writes_total, input ready);
    modport sink   (input valid, input action, input target_page,
                    input target_frame, input last, input faults_total,
                    input reads_total, input writes_total, output ready);
endinterface

interface fdpf_cfg_if import fdpf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/fifo_demand_paging_fault_unit_core.sv -----
// ----------------------------------------------------------------------------
// fifo_demand_paging_fault_unit_core
// page fault handler with fifo frame replacement and dirty write-back
// ----------------------------------------------------------------------------
// Each transfer on i_fault names a faulting page. A page that is already
// mapped gets write permission (one grant result). An unmapped page takes
// the frame under the fifo pointer; the page table is scanned from page 0,
// one entry per cycle through the single read port of the table ram, for
// the first page holding that frame. A dirty owner first gives a write-back
// result, then the new mapping gives a read result marked last. Faults on
// pages not below pages_in_use are dropped. The next fault is taken once the
// last result sits in the output register. The table resets unmapped
// through per-page valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module fifo_demand_paging_fault_unit_core import fdpf_pkg::*; #(
    parameter int MAX_PAGES  = 64,
    parameter int MAX_FRAMES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdpf_in_if.sink    i_fault,
    fdpf_cfg_if.sink   i_cfg,
    fdpf_out_if.source o_result
);

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_fault.ready = w_in_ready;

    // fault sequencer
    fdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_fault.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // page table, pointer, counters and result register
    fdpf_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_page   (i_fault.fault_page),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule

// ----- design/fdpf_ram.sv -----
// ----------------------------------------------------------------------------
// fdpf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fdpf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fdpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdpf_ctrl
// sequencer of one fault: lookup, owner scan, table update, results
// ----------------------------------------------------------------------------
module fdpf_ctrl import fdpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_OUT_GR = 3'd4;
    localparam logic [2:0] S_OUT_WB = 3'd5;
    localparam logic [2:0] S_OUT_RD = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.page_ok) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.mapped ? S_OUT_GR : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || !i_sts.scan_more) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.dirty ? S_OUT_WB : S_OUT_RD;
            end
            S_OUT_GR: begin
                o_cmd.kind = ACT_GRANT;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_OUT_WB: begin
                o_cmd.kind = ACT_WRITE;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.kind = ACT_READ;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // write-back only follows a dirty owner
    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT_WB |-> i_sts.dirty)
        else $error("write-back result without dirty owner");

    // a fault beyond the pages in use is dropped
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take && !i_sts.page_ok |=> r_state == S_IDLE)
        else $error("out of range fault was not dropped");

endmodule

// ----- design/fdpf_dp.sv -----
// ----------------------------------------------------------------------------
// fdpf_dp
// page table, fifo pointer, counters, configuration and result register
// ----------------------------------------------------------------------------
module fdpf_dp import fdpf_pkg::*; #(
    parameter int MAX_PAGES  = 64,
    parameter int MAX_FRAMES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PAGE_W-1:0] i_page,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    fdpf_cfg_if.sink          i_cfg,
    fdpf_out_if.source        o_result
);

    localparam int PT_DEPTH = (MAX_PAGES < 64) ? MAX_PAGES : 64;
    localparam int PW       = $clog2(PT_DEPTH);
    localparam int SW       = PW + 1;
    localparam int FR_LIM   = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
    localparam logic [FRM_CFG_W-1:0] FR_LIM_V = FRM_CFG_W'(FR_LIM);
    localparam logic [PG_CFG_W-1:0]  PG_LIM_V = PG_CFG_W'(PT_DEPTH);

    // configuration
    logic [FRM_CFG_W-1:0] r_frames_cfg;
    logic [PG_CFG_W-1:0]  r_pages_cfg;
    logic [FRM_CFG_W-1:0] w_nf;
    logic [PG_CFG_W-1:0]  w_np;

    // fault state
    logic [PAGE_W-1:0]  r_page;
    logic [PW-1:0]      w_page_idx;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_fifo_ptr;
    logic [FRAME_W-1:0] w_victim;
    logic [FRAME_W-1:0] w_ptr_next;
    logic [FRM_CFG_W-1:0] w_vic_inc;
    logic [SW-1:0]      r_scan_idx;
    logic               w_scan_more;
    logic               r_chk;
    logic [PW-1:0]      r_owner;
    logic               r_has_owner;
    logic               r_dirty;
    logic               w_hit;

    // table
    logic               r_map_vld [PT_DEPTH];
    logic [PW-1:0]      w_raddr;
    logic [PW-1:0]      r_rd_idx;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry             w_rd_entry;
    logic               w_rd_vld;
    logic               w_we;
    t_entry             w_wdata;

    // counters
    logic [CNT_W-1:0] r_faults;
    logic [CNT_W-1:0] r_reads;
    logic [CNT_W-1:0] r_writes;

    // result register
    logic               r_out_vld;
    logic [ACT_W-1:0]   r_out_act;
    logic [PAGE_W-1:0]  r_out_page;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_last;
    logic [CNT_W-1:0]   r_out_faults;
    logic [CNT_W-1:0]   r_out_reads;
    logic [CNT_W-1:0]   r_out_writes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= RST_FRAMES;
            r_pages_cfg  <= RST_PAGES;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_FRAMES) begin
                r_frames_cfg <= i_cfg.data[FRM_CFG_W-1:0];
            end else if (i_cfg.index == CFG_PAGES) begin
                r_pages_cfg <= i_cfg.data[PG_CFG_W-1:0];
            end
        end
    end

    // clamp registers into their useful range
    always_comb begin
        if (r_frames_cfg == '0) begin
            w_nf = FRM_CFG_W'(1);
        end else if (r_frames_cfg > FR_LIM_V) begin
            w_nf = FR_LIM_V;
        end else begin
            w_nf = r_frames_cfg;
        end
        if (r_pages_cfg == '0) begin
            w_np = PG_CFG_W'(1);
        end else if (r_pages_cfg > PG_LIM_V) begin
            w_np = PG_LIM_V;
        end else begin
            w_np = r_pages_cfg;
        end
    end

    assign w_page_idx  = r_page[PW-1:0];
    assign w_scan_more = r_scan_idx < SW'(w_np);

    // fifo victim and next pointer
    assign w_victim   = ({1'b0, r_fifo_ptr} < w_nf) ? r_fifo_ptr : '0;
    assign w_vic_inc  = {1'b0, w_victim} + FRM_CFG_W'(1);
    assign w_ptr_next = (w_vic_inc >= w_nf) ? '0 : w_vic_inc[FRAME_W-1:0];

    always_comb begin
        priority if (i_cmd.take) begin
            w_raddr = i_page[PW-1:0];
        end else if (i_cmd.scan) begin
            w_raddr = r_scan_idx[PW-1:0];
        end else begin
            w_raddr = w_page_idx;
        end
    end

    assign w_rd_entry = t_entry'(w_rdata);
    assign w_rd_vld   = r_map_vld[r_rd_idx];
    assign w_hit      = r_chk && w_rd_vld && (w_rd_entry.frame == r_frame);

    // grant sets the write mark, update maps the page read-only
    assign w_we          = (i_cmd.look && w_rd_vld) || i_cmd.update;
    assign w_wdata.dirty = !i_cmd.update;
    assign w_wdata.frame = i_cmd.update ? r_frame : w_rd_entry.frame;

    fdpf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (PT_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_page_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_raddr;
        if (i_cmd.take) begin
            r_page <= i_page;
        end
        if (i_cmd.look) begin
            if (w_rd_vld) begin
                r_frame <= w_rd_entry.frame;
            end else begin
                r_frame    <= w_victim;
                r_scan_idx <= '0;
                r_owner    <= '0;
            end
        end
        if (i_cmd.scan) begin
            if (w_scan_more) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (w_hit) begin
                r_owner <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PT_DEPTH; i++) begin
                r_map_vld[i] <= 1'b0;
            end
            r_fifo_ptr  <= '0;
            r_faults    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_chk       <= 1'b0;
            r_has_owner <= 1'b0;
            r_dirty     <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan && w_scan_more;
            if (i_cmd.look) begin
                if (w_rd_vld) begin
                    r_faults <= r_faults + CNT_W'(1);
                end else begin
                    r_fifo_ptr  <= w_ptr_next;
                    r_has_owner <= 1'b0;
                    r_dirty     <= 1'b0;
                end
            end
            if (i_cmd.scan && w_hit) begin
                r_has_owner <= 1'b1;
                r_dirty     <= w_rd_entry.dirty;
            end
            if (i_cmd.update) begin
                if (r_has_owner) begin
                    r_map_vld[r_owner] <= 1'b0;
                end
                r_map_vld[w_page_idx] <= 1'b1;
                r_faults <= r_faults + CNT_W'(1);
                r_reads  <= r_reads + CNT_W'(1);
                r_writes <= r_writes + CNT_W'(r_dirty);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_act    <= i_cmd.kind;
            r_out_page   <= (i_cmd.kind == ACT_WRITE) ? PAGE_W'(r_owner) : r_page;
            r_out_frame  <= r_frame;
            r_out_last   <= (i_cmd.kind != ACT_WRITE);
            r_out_faults <= r_faults;
            r_out_reads  <= r_reads;
            r_out_writes <= r_writes;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.action       = r_out_act;
    assign o_result.target_page  = r_out_page;
    assign o_result.target_frame = r_out_frame;
    assign o_result.last         = r_out_last;
    assign o_result.faults_total = r_out_faults;
    assign o_result.reads_total  = r_out_reads;
    assign o_result.writes_total = r_out_writes;

    assign o_sts.page_ok   = PG_CFG_W'(i_page) < w_np;
    assign o_sts.mapped    = w_rd_vld;
    assign o_sts.hit       = w_hit;
    assign o_sts.scan_more = w_scan_more;
    assign o_sts.dirty     = r_dirty;
    assign o_sts.out_free  = !r_out_vld || o_result.ready;

    // the faulting page is mapped after the update
    a_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_map_vld[$past(w_page_idx)])
        else $error("faulting page not mapped after update");

    // the victim frame lies within the frames in use
    a_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> ({1'b0, r_frame} < w_nf))
        else $error("victim frame beyond frames in use");

endmodule

// ----- tb/fdpf_checker.sv -----
// ----------------------------------------------------------------------------
// fdpf_checker
// watches the fault, configuration and result channels, keeps its own copy
// of the page table and counters, and compares every result transfer with
// the oldest predicted one
// ----------------------------------------------------------------------------
module fdpf_checker import fdpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fdpf_in_if   fault_ch,
    fdpf_cfg_if  cfg_ch,
    fdpf_out_if  result_ch,
    output int   o_fail_count,
    output int   o_in_flight,
    output int   o_faults_seen,
    output int   o_dropped,
    output int   o_checked,
    output int   o_grants,
    output int   o_writebacks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PAGES  = 64;
    localparam int NUM_FRAMES = 16;

    // frame in the low bits, read mark, write mark on top
    typedef struct packed {
        logic               wr;
        logic               rd;
        logic [FRAME_W-1:0] frame;
    } t_pte;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               last;
        logic [CNT_W-1:0]   faults;
        logic [CNT_W-1:0]   reads;
        logic [CNT_W-1:0]   writes;
    } t_paging_result;

    t_pte                 page_tbl [NUM_PAGES];
    int unsigned          fifo_ptr;
    logic [CNT_W-1:0]     fault_cnt;
    logic [CNT_W-1:0]     read_cnt;
    logic [CNT_W-1:0]     write_cnt;
    logic [FRM_CFG_W-1:0] frames_reg;
    logic [PG_CFG_W-1:0]  pages_reg;
    t_paging_result       due_results [$];

    function automatic int unsigned frames_active();
        int unsigned n;
        n = frames_reg;
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        return n;
    endfunction

    function automatic int unsigned pages_active();
        int unsigned n;
        n = pages_reg;
        if (n == 0) n = 1;
        if (n > NUM_PAGES) n = NUM_PAGES;
        return n;
    endfunction

    function automatic t_paging_result make_result(logic [ACT_W-1:0] act,
            logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] frm, logic lst);
        t_paging_result r;
        r.action = act;
        r.page   = pg;
        r.frame  = frm;
        r.last   = lst;
        r.faults = fault_cnt;
        r.reads  = read_cnt;
        r.writes = write_cnt;
        return r;
    endfunction

    function automatic string fmt_result(t_paging_result r);
        return $sformatf("act=%0d page=%0d frame=%0d last=%0b faults=%0d reads=%0d writes=%0d",
                         r.action, r.page, r.frame, r.last, r.faults, r.reads, r.writes);
    endfunction

    // page table update and expected results for one fault transfer
    task automatic map_fault(input logic [PAGE_W-1:0] pg);
        int unsigned np;
        int unsigned nf;
        int unsigned victim;
        int unsigned owner;
        logic        found;
        logic        dirty;
        np = pages_active();
        nf = frames_active();
        o_faults_seen++;
        if (pg >= np) begin
            o_dropped++;
            return;
        end
        // already mapped: permission fault, grant write
        if (page_tbl[pg] != '0) begin
            page_tbl[pg].wr = 1'b1;
            fault_cnt++;
            o_grants++;
            due_results.push_back(make_result(ACT_GRANT, pg, page_tbl[pg].frame, 1'b1));
            return;
        end
        // pointer left beyond a shrunk frame count falls back to frame 0
        victim   = (fifo_ptr < nf) ? fifo_ptr : 0;
        fifo_ptr = (victim + 1 >= nf) ? 0 : victim + 1;
        found = 1'b0;
        dirty = 1'b0;
        owner = 0;
        for (int i = 0; i < np && !found; i++) begin
            if (page_tbl[i] != '0 && page_tbl[i].frame == FRAME_W'(victim)) begin
                found = 1'b1;
                owner = i;
                dirty = page_tbl[i].wr;
            end
        end
        if (found) page_tbl[owner] = '0;
        if (dirty) write_cnt++;
        read_cnt++;
        fault_cnt++;
        page_tbl[pg].wr    = 1'b0;
        page_tbl[pg].rd    = 1'b1;
        page_tbl[pg].frame = FRAME_W'(victim);
        if (dirty) begin
            o_writebacks++;
            due_results.push_back(make_result(ACT_WRITE, PAGE_W'(owner),
                                              FRAME_W'(victim), 1'b0));
        end
        due_results.push_back(make_result(ACT_READ, pg, FRAME_W'(victim), 1'b1));
    endtask

    task automatic check_result();
        t_paging_result got;
        t_paging_result want;
        got.action = result_ch.action;
        got.page   = result_ch.target_page;
        got.frame  = result_ch.target_frame;
        got.last   = result_ch.last;
        got.faults = result_ch.faults_total;
        got.reads  = result_ch.reads_total;
        got.writes = result_ch.writes_total;
        if (due_results.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t ns: unexpected result %s", $time, fmt_result(got));
            o_fail_count++;
            return;
        end
        want = due_results.pop_front();
        o_checked++;
        if (got.action !== want.action || got.page !== want.page ||
            got.frame !== want.frame || got.last !== want.last ||
            got.faults !== want.faults || got.reads !== want.reads ||
            got.writes !== want.writes) begin
            if (o_fail_count < 10) begin
                $display("%0t ns: result mismatch", $time);
                $display("  expected %s", fmt_result(want));
                $display("  actual   %s", fmt_result(got));
            end
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_tbl[i]) page_tbl[i] = '0;
            fifo_ptr      = 0;
            fault_cnt     = '0;
            read_cnt      = '0;
            write_cnt     = '0;
            frames_reg    = RST_FRAMES;
            pages_reg     = RST_PAGES;
            due_results.delete();
            o_fail_count  = 0;
            o_faults_seen = 0;
            o_dropped     = 0;
            o_checked     = 0;
            o_grants      = 0;
            o_writebacks  = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) check_result();
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_FRAMES: begin
                        frames_reg = cfg_ch.data[FRM_CFG_W-1:0];
                    end
                    CFG_PAGES: begin
                        pages_reg = cfg_ch.data[PG_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (fault_ch.valid && fault_ch.ready) map_fault(fault_ch.fault_page);
        end
        o_in_flight = due_results.size();
    end

endmodule

// ----- tb/tb_fifo_demand_paging_fault_unit_core.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_demand_paging_fault_unit_core
// drives page faults and register writes into the fault unit and gives the
// verdict; prediction and comparison live in fdpf_checker
// ----------------------------------------------------------------------------
module tb_fifo_demand_paging_fault_unit_core;
    import fdpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // a miss scans up to 64 entries before the table update
    localparam int SETTLE_CYCLES = 100;
    // generous ceiling, far above the slowest legal run
    localparam int TIMEOUT_NS    = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fdpf_in_if  fault_ch ();
    fdpf_cfg_if cfg_ch ();
    fdpf_out_if result_ch ();

    // idle chance per cycle, in percent, for each side
    int tx_idle_pct;
    int rx_idle_pct;
    int settings_used;

    int fail_count;
    int in_flight;
    int faults_seen;
    int dropped;
    int checked;
    int grants;
    int writebacks;

    always #1 i_clk = ~i_clk;

    fifo_demand_paging_fault_unit_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fault  (fault_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    fdpf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .fault_ch      (fault_ch),
        .cfg_ch        (cfg_ch),
        .result_ch     (result_ch),
        .o_fail_count  (fail_count),
        .o_in_flight   (in_flight),
        .o_faults_seen (faults_seen),
        .o_dropped     (dropped),
        .o_checked     (checked),
        .o_grants      (grants),
        .o_writebacks  (writebacks)
    );

    // one fault transfer; entered and left at a falling edge, valid stays
    // high on exit so back-to-back faults need no extra assignment
    task automatic send_fault(input logic [PAGE_W-1:0] pg);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            fault_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        fault_ch.valid      <= 1'b1;
        fault_ch.fault_page <= pg;
        do @(posedge i_clk); while (!fault_ch.ready);
        @(negedge i_clk);
    endtask

    // stop sending, wait for every predicted result, then let a dropped
    // fault or a scan still in progress run out
    task automatic settle();
        fault_ch.valid <= 1'b0;
        do @(negedge i_clk); while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // raw register values, out of range ones included
    task automatic set_sizes(input int frames, input int pages);
        settle();
        write_reg(CFG_FRAMES, CFG_DATA_W'(frames));
        write_reg(CFG_PAGES, CFG_DATA_W'(pages));
        settings_used++;
    endtask

    // random faults over pages 0..span-1, about one in ten beyond span when
    // there is room; only faults inside span count toward n_items
    task automatic fault_burst(input int n_items, input int span);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if (span < 64 && $urandom_range(0, 9) == 0) begin
                send_fault(PAGE_W'($urandom_range(span, 63)));
            end else begin
                send_fault(PAGE_W'($urandom_range(0, span - 1)));
                sent++;
            end
        end
    endtask

    // result side ready, rolled every cycle
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // run ceiling
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int frames;
        int pages;
        i_rst_n             = 1'b0;
        fault_ch.valid      = 1'b0;
        fault_ch.fault_page = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_FRAMES;
        cfg_ch.data         = '0;
        tx_idle_pct         = 11;
        rx_idle_pct         = 66;
        settings_used       = 1;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset sizes of 16 frames and 64 pages
        // cold misses with no owner, both extreme pages, then grants and two more misses
        send_fault(PAGE_W'(0));
        send_fault(PAGE_W'(63));
        send_fault(PAGE_W'(0));
        send_fault(PAGE_W'(63));
        send_fault(PAGE_W'(21));
        send_fault(PAGE_W'(42));

        // shrink to 2 frames: pointer sits beyond them so frame 0 is taken,
        // its owner is dirty (write-back), next victim owner is dirty too,
        // then frame 0 again with a clean read-only owner
        set_sizes(2, 64);
        send_fault(PAGE_W'(5));
        send_fault(PAGE_W'(6));
        send_fault(PAGE_W'(7));

        // pages beyond the page count are dropped; a mapped page still grants
        set_sizes(2, 8);
        send_fault(PAGE_W'(63));
        send_fault(PAGE_W'(8));
        send_fault(PAGE_W'(6));

        // zero sizes act as one frame and one page; the real holder of
        // frame 0 lies outside the scan so no owner is found
        set_sizes(0, 0);
        send_fault(PAGE_W'(0));
        send_fault(PAGE_W'(1));
        send_fault(PAGE_W'(0));
        send_fault(PAGE_W'(0));

        // oversize values clamp to 16 frames and 64 pages
        set_sizes(31, 127);
        send_fault(PAGE_W'(63));
        send_fault(PAGE_W'(1));
        send_fault(PAGE_W'(2));
        send_fault(PAGE_W'(63));

        // random part, sender mostly busy, receiver mostly stalled
        set_sizes(16, 64);
        fault_burst(150, 64);
        set_sizes(4, 12);
        fault_burst(120, 12);

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 66;
        rx_idle_pct = 11;
        set_sizes(1, 2);
        fault_burst(80, 2);
        set_sizes(31, 127);
        fault_burst(60, 64);
        // hold off until every result is back, then resume
        settle();
        fault_burst(60, 64);

        // no idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_sizes(7, 40);
        fault_burst(130, 40);
        repeat (4) begin
            frames = $urandom_range(1, 16);
            pages  = $urandom_range(1, 64);
            set_sizes(frames, pages);
            fault_burst(50, pages);
        end

        settle();

        $display("run covered %0d faults (%0d dropped) over %0d size settings",
                 faults_seen, dropped, settings_used);
        $display("checked %0d results: %0d write grants, %0d write-backs",
                 checked, grants, writebacks);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/fdpf_pkg.sv
design/fdpf_if.sv
design/fdpf_ram.sv
design/fdpf_ctrl.sv
design/fdpf_dp.sv
design/fifo_demand_paging_fault_unit_core.sv
tb/fdpf_checker.sv
tb/tb_fifo_demand_paging_fault_unit_core.sv
